// ----- hw/rtl/sha256_pkg.sv -----
// Shared types, states and constant tables of the SHA-256 byte-stream hasher.
package sha256_pkg;

    localparam int unsigned BLOCK_BYTES   = 64;
    localparam int unsigned LENGTH_OFFSET = 56;
    localparam int unsigned ROUNDS        = 64;
    localparam logic [7:0]  PAD_MARK      = 8'h80;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } sha_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_ROUND,
        ST_UPDATE,
        ST_OUT
    } sha_state_t;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// ----- hw/rtl/sha256_byte_stream_hasher_unit.sv -----
// SHA-256 byte-stream hasher: byte loading, padding, one round per cycle, digest output.
//
// Streams a message in one byte per word (op = absorb) and, on a finish word,
// pads it the standard way and returns the eight digest words h0..h7, each
// with its word_index and with last_word on the eighth; the hash then restarts
// from the initial values for the next message (an empty message is fine).
// Every 64th byte of a message starts a compression: the 64 rounds through the
// single round unit, then a fold of the working variables into the hash. A
// finish word pads byte by byte up to the length field, inserts the 64-bit
// length and runs one compression, or two when fewer than nine bytes of the
// block are left, then delivers the digest words as the sink takes them. No
// new word is taken while padding, a compression or digest delivery runs. The
// round unit sets the pace on long messages.
module sha256_byte_stream_hasher_unit
    import sha256_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sha_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output sha_out_t m_data
);

    sha_state_t  state_reg, state_next;

    // 512-bit window: holds the block bytes while loading, then rolls as the schedule.
    logic [31:0] window_reg [16];
    logic [31:0] window_next [16];
    logic [31:0] vars_reg [8];        // a..h
    logic [31:0] vars_next [8];
    logic [31:0] hash_reg [8];
    logic [31:0] hash_next [8];

    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bitlen_reg, bitlen_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        finish_reg, finish_next;   // finish in progress
    logic        len_done_reg, len_done_next; // last block (with length) is in flight
    logic        wrap_reg, wrap_next;       // padding must skip the length field and spill into a second block

    logic        pad_at_len;

    assign pad_at_len = (fill_reg == 6'(LENGTH_OFFSET)) && !wrap_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (fill_reg == 6'(BLOCK_BYTES - 1)) begin
                        state_next = ST_ROUND;
                    end else if (s_data.op == OP_FINISH) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (pad_at_len) begin
                    state_next = ST_LEN;
                end else if (fill_reg == 6'(BLOCK_BYTES - 1)) begin
                    state_next = ST_ROUND;
                end
            end
            ST_LEN: state_next = ST_ROUND;
            ST_ROUND: begin
                if (round_reg == 6'(ROUNDS - 1)) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (!finish_reg) begin
                    state_next = ST_IDLE;
                end else if (len_done_reg) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_PAD;
                end
            end
            ST_OUT: begin
                if (m_ready && (out_idx_reg == 3'd7)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_OUT:  m_valid = 1'b1;
            default: begin
                s_ready = 1'b0;
                m_valid = 1'b0;
            end
        endcase
    end

    assign m_data.digest_word = hash_reg[out_idx_reg];
    assign m_data.word_index  = out_idx_reg;
    assign m_data.last_word   = (out_idx_reg == 3'd7);

    // datapath
    always_comb begin
        logic [7:0]  in_byte;
        logic [31:0] t1;
        logic [31:0] t2;
        logic [31:0] ch;
        logic [31:0] maj;
        logic [31:0] w_new;

        window_next   = window_reg;
        vars_next     = vars_reg;
        hash_next     = hash_reg;
        fill_next     = fill_reg;
        bitlen_next   = bitlen_reg;
        round_next    = round_reg;
        out_idx_next  = out_idx_reg;
        finish_next   = finish_reg;
        len_done_next = len_done_reg;
        wrap_next     = wrap_reg;

        in_byte = (s_data.op == OP_FINISH) ? PAD_MARK : s_data.data_byte;

        ch    = (vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]);
        maj   = (vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
              ^ (vars_reg[1] & vars_reg[2]);
        t1    = vars_reg[7] + big_sigma1(vars_reg[4]) + ch + ROUND_K[round_reg]
              + window_reg[0];
        t2    = big_sigma0(vars_reg[0]) + maj;
        w_new = small_sigma1(window_reg[14]) + window_reg[9]
              + small_sigma0(window_reg[1]) + window_reg[0];

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    for (int i = 0; i < 15; i++) begin
                        window_next[i] = {window_reg[i][23:0], window_reg[i+1][31:24]};
                    end
                    window_next[15] = {window_reg[15][23:0], in_byte};
                    fill_next = fill_reg + 6'd1;
                    if (s_data.op == OP_ABSORB) begin
                        bitlen_next = bitlen_reg + 64'd8;
                    end else begin
                        finish_next = 1'b1;
                        wrap_next   = fill_reg inside {[6'(LENGTH_OFFSET):6'(BLOCK_BYTES - 2)]};
                    end
                    if (fill_reg == 6'(BLOCK_BYTES - 1)) begin
                        vars_next  = hash_reg;
                        round_next = '0;
                    end
                end
            end
            ST_PAD: begin
                if (!pad_at_len) begin
                    for (int i = 0; i < 15; i++) begin
                        window_next[i] = {window_reg[i][23:0], window_reg[i+1][31:24]};
                    end
                    window_next[15] = {window_reg[15][23:0], 8'h00};
                    fill_next = fill_reg + 6'd1;
                    if (fill_reg == 6'(BLOCK_BYTES - 1)) begin
                        vars_next  = hash_reg;
                        round_next = '0;
                        wrap_next  = 1'b0;
                    end
                end
            end
            ST_LEN: begin
                // bytes 0..55 sit in words 2..15; slide two words and append the length
                for (int i = 0; i < 14; i++) begin
                    window_next[i] = window_reg[i+2];
                end
                window_next[14] = bitlen_reg[63:32];
                window_next[15] = bitlen_reg[31:0];
                fill_next     = '0;
                len_done_next = 1'b1;
                vars_next     = hash_reg;
                round_next    = '0;
            end
            ST_ROUND: begin
                for (int i = 0; i < 15; i++) begin
                    window_next[i] = window_reg[i+1];
                end
                window_next[15] = w_new;
                vars_next[7] = vars_reg[6];
                vars_next[6] = vars_reg[5];
                vars_next[5] = vars_reg[4];
                vars_next[4] = vars_reg[3] + t1;
                vars_next[3] = vars_reg[2];
                vars_next[2] = vars_reg[1];
                vars_next[1] = vars_reg[0];
                vars_next[0] = t1 + t2;
                round_next   = round_reg + 6'd1;
            end
            ST_UPDATE: begin
                for (int i = 0; i < 8; i++) begin
                    hash_next[i] = hash_reg[i] + vars_reg[i];
                end
                out_idx_next = '0;
            end
            ST_OUT: begin
                if (m_ready) begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == 3'd7) begin
                        hash_next     = H_INIT;
                        fill_next     = '0;
                        bitlen_next   = '0;
                        finish_next   = 1'b0;
                        len_done_next = 1'b0;
                        wrap_next     = 1'b0;
                    end
                end
            end
            default: begin
                fill_next = fill_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            hash_reg     <= H_INIT;
            fill_reg     <= '0;
            bitlen_reg   <= '0;
            round_reg    <= '0;
            out_idx_reg  <= '0;
            finish_reg   <= 1'b0;
            len_done_reg <= 1'b0;
            wrap_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            hash_reg     <= hash_next;
            fill_reg     <= fill_next;
            bitlen_reg   <= bitlen_next;
            round_reg    <= round_next;
            out_idx_reg  <= out_idx_next;
            finish_reg   <= finish_next;
            len_done_reg <= len_done_next;
            wrap_reg     <= wrap_next;
        end
    end

    always_ff @(posedge aclk) begin
        window_reg <= window_next;
        vars_reg   <= vars_next;
    end

    // input is never taken while the digest is being delivered
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while digest pending");

    // a finish word always drops s_ready to start its work
    a_finish_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.op == OP_FINISH)) |=> !s_ready)
        else $error("ready right after finish");

    // digest words come out in order without gaps
    a_word_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.last_word) |=>
            (m_valid && (m_data.word_index == 3'($past(m_data.word_index) + 3'd1))))
        else $error("digest word order broken");

    // the eighth word ends the digest
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.last_word) |=> (!m_valid && s_ready))
        else $error("digest did not end after last word");

endmodule
